[rtl/core/dmxrx_pkg.sv]
// Shared types and constants of the DMX512 frame receiver.
`default_nettype none

package dmxrx_pkg;

   // Default number of channels in one frame
   localparam int MAX_CHANNELS_DEF = 512;

   // Field widths of the channels
   localparam int ACTION_W  = 3;
   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 10;
   localparam int COUNT_W   = 10;
   localparam int STATE_W   = 3;
   localparam int MS_W      = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   // Action codes of an input word
   localparam logic [ACTION_W-1:0] ACT_BYTE        = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ERROR       = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK        = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ        = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RESET_FRAME = 3'd4;

   // Register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BREAK  = 1'd1;

   // Register reset values
   localparam logic [CSR_DAT_W-1:0] START_CODE_RST = 8'd0;
   localparam logic [CSR_DAT_W-1:0] MIN_BREAK_RST  = 8'd1;

   // Millisecond counter saturation point
   localparam logic [MS_W-1:0] MS_SAT = 8'hFF;

   // Receiver phase
   typedef enum logic [STATE_W-1:0] {
      PH_IDLE  = 3'd0,
      PH_BREAK = 3'd1,
      PH_START = 3'd2,
      PH_DATA  = 3'd3,
      PH_ERROR = 3'd4
   } phase_type;

   // Input word
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   rx_byte;
      logic                framing_error;
      logic                other_error;
      logic [INDEX_W-1:0]  channel_index;
   } req_type;

   // Result word
   typedef struct packed {
      logic [BYTE_W-1:0]  channel_value;
      logic               frame_done;
      logic [COUNT_W-1:0] channels_received;
      logic [STATE_W-1:0] receiver_state;
   } rsp_type;

   // Status carried beside the channel read while it completes
   typedef struct packed {
      logic               rd_hit;
      logic               frame_done;
      logic [COUNT_W-1:0] channels_received;
      logic [STATE_W-1:0] receiver_state;
   } meta_type;

endpackage

`default_nettype wire

[rtl/core/dmxrx_chan_mem.sv]
// Channel level memory: one write port, one registered read port.
`default_nettype none

module dmxrx_chan_mem
   import dmxrx_pkg::*;
#(
   parameter int DEPTH = MAX_CHANNELS_DEF + 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [BYTE_W-1:0]        rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write a channel level
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read a channel level, hold it otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/dmx512_frame_receiver.sv]
// DMX512 frame receiver: top level with phase machine, channel store and result buffer.
//
// Use: each word on the req_ channel is one UART event (byte, error, millisecond
// tick), a channel read or a frame reset. Every accepted word gives exactly one
// word on the rsp_ channel with the read level, frame-done flag, channel count
// and receiver phase as they stand after that word.
// Control registers (start code, minimum break length) on the csr_ port must be written
// only while no word is in flight; the block itself does not enforce this.
// Order: the phase machine updates and the channel memory read is registered when a
// word is accepted; the result then moves to the output register once that slot is
// free, and is offered on rsp_ from there.
// Throughput: one word per cycle while req_stall is low, set by the single read port of
// the channel memory and the update of the phase registers on each accepted word.
// Stall: the read stage and the output register form two slots, so the block
// keeps taking words while a result waits; it stalls only when both are full.
// Reset: clears phase, counters, flags and the written-channel mark; channels
// beyond the mark read as zero, so no clearing pass of the memory is needed.
`default_nettype none

module dmx512_frame_receiver
   import dmxrx_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int DEPTH  = MAX_CHANNELS + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = $clog2(MAX_CHANNELS + 2);
   localparam logic [SLOT_W-1:0]  SLOT_MAX  = SLOT_W'(MAX_CHANNELS);
   localparam logic [SLOT_W-1:0]  SLOT_ONE  = SLOT_W'(1);
   localparam logic [SLOT_W-1:0]  SLOT_TWO  = SLOT_W'(2);
   localparam logic [INDEX_W-1:0] INDEX_MAX = INDEX_W'(MAX_CHANNELS);

   // Control registers
   logic [BYTE_W-1:0] start_code_ff;
   logic [MS_W-1:0]   min_break_ff;

   // Frame state
   phase_type         phase_ff, phase_in;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [SLOT_W-1:0] slot_total_ff, slot_total_in;
   logic              done_ff, done_in;
   logic              pending_ff, pending_in;
   logic [MS_W-1:0]   ms_ff, ms_in;
   logic [SLOT_W-1:0] fill_ff;

   // Pipeline slots
   logic     s1_valid_ff, s1_valid_in;
   meta_type s1_meta_ff, s1_meta_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              s1_move;
   logic              is_byte;
   logic              in_data;
   logic              data_write;
   logic              rd_hit;
   logic [BYTE_W-1:0] rd_data;

   // Handshake: advance the read stage when the output slot frees up
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign is_byte    = (req_data.action == ACT_BYTE);
   assign in_data    = (phase_ff == PH_DATA) && (next_slot_ff <= SLOT_MAX);
   assign data_write = accept && is_byte && in_data;

   // Read hits only written channels inside the frame
   assign rd_hit = (req_data.action == ACT_READ) && (req_data.channel_index != '0)
                   && (req_data.channel_index <= INDEX_MAX)
                   && (req_data.channel_index <= INDEX_W'(fill_ff));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (req_data.action)
         ACT_BYTE: begin
            case (phase_ff)
               PH_IDLE: phase_in = PH_IDLE;
               PH_BREAK: begin
                  if (pending_ff && (ms_ff >= min_break_ff)) begin
                     phase_in = PH_START;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_START: begin
                  phase_in = (req_data.rx_byte == start_code_ff) ? PH_DATA : PH_IDLE;
               end
               PH_DATA: begin
                  phase_in = (next_slot_ff <= SLOT_MAX) ? PH_DATA : PH_IDLE;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         ACT_ERROR: begin
            if (req_data.other_error) begin
               phase_in = PH_ERROR;
            end else if (req_data.framing_error) begin
               phase_in = PH_BREAK;
            end
         end
         ACT_RESET_FRAME: phase_in = PH_IDLE;
         default: phase_in = phase_ff;
      endcase
   end

   // Counters and flags
   always_comb begin
      next_slot_in  = next_slot_ff;
      slot_total_in = slot_total_ff;
      done_in       = done_ff;
      pending_in    = pending_ff;
      ms_in         = ms_ff;
      case (req_data.action)
         ACT_BYTE: begin
            case (phase_ff)
               PH_BREAK: begin
                  if (pending_ff && (ms_ff >= min_break_ff)) begin
                     next_slot_in = '0;
                     pending_in   = 1'b0;
                  end
               end
               PH_START: begin
                  if (req_data.rx_byte == start_code_ff) begin
                     next_slot_in = SLOT_ONE;
                  end
               end
               PH_DATA: begin
                  if (next_slot_ff <= SLOT_MAX) begin
                     next_slot_in = next_slot_ff + SLOT_ONE;
                     if (next_slot_ff >= SLOT_TWO) begin
                        slot_total_in = next_slot_ff;
                        done_in       = 1'b1;
                     end
                  end else begin
                     slot_total_in = SLOT_MAX;
                     done_in       = 1'b1;
                  end
               end
               default: begin
                  next_slot_in = next_slot_ff;
               end
            endcase
         end
         ACT_ERROR: begin
            if (req_data.framing_error) begin
               pending_in = 1'b1;
               ms_in      = '0;
            end
         end
         ACT_TICK: begin
            if (ms_ff != MS_SAT) begin
               ms_in = ms_ff + MS_W'(1);
            end
         end
         ACT_RESET_FRAME: begin
            done_in       = 1'b0;
            next_slot_in  = '0;
            slot_total_in = '0;
         end
         default: begin
            ms_in = ms_ff;
         end
      endcase
   end

   // Status as it stands after this word
   always_comb begin
      s1_meta_in.rd_hit            = rd_hit;
      s1_meta_in.frame_done        = done_in;
      s1_meta_in.channels_received = COUNT_W'(slot_total_in);
      s1_meta_in.receiver_state    = phase_in;
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   // Build the result word from the read stage
   always_comb begin
      rsp_data_in.channel_value     = s1_meta_ff.rd_hit ? rd_data : '0;
      rsp_data_in.frame_done        = s1_meta_ff.frame_done;
      rsp_data_in.channels_received = s1_meta_ff.channels_received;
      rsp_data_in.receiver_state    = s1_meta_ff.receiver_state;
   end

   // Channel store
   dmxrx_chan_mem #(
      .DEPTH (DEPTH)
   ) u_chan_mem (
      .clock   (clock),
      .wr_en   (data_write),
      .wr_addr (next_slot_ff[ADDR_W-1:0]),
      .wr_data (req_data.rx_byte),
      .rd_en   (accept && rd_hit),
      .rd_addr (req_data.channel_index[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RST;
         min_break_ff  <= MIN_BREAK_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_START_CODE: start_code_ff <= csr_wdata;
            CSR_MIN_BREAK:  min_break_ff  <= csr_wdata;
            default: start_code_ff <= start_code_ff;
         endcase
      end
   end

   // Update frame state on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         next_slot_ff  <= '0;
         slot_total_ff <= '0;
         done_ff       <= 1'b0;
         pending_ff    <= 1'b0;
         ms_ff         <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         next_slot_ff  <= next_slot_in;
         slot_total_ff <= slot_total_in;
         done_ff       <= done_in;
         pending_ff    <= pending_in;
         ms_ff         <= ms_in;
      end
   end

   // Advance the written-channel mark
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (data_write && (next_slot_ff > fill_ff)) begin
         fill_ff <= next_slot_ff;
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pipeline payload: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[bench/dmxrx_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the DMX512 frame receiver bench: channel store predictor and result checks.
package dmxrx_tb_pkg;
   import dmxrx_pkg::*;

   // Highest action code; codes above ACT_RESET_FRAME do nothing
   localparam logic [ACTION_W-1:0] ACT_TOP = 3'd7;
   // Lowest action code without a meaning
   localparam logic [ACTION_W-1:0] ACT_SPARE = 3'd5;
   // Mismatch lines printed before going quiet (all are still counted)
   localparam int PRINT_CAP = 30;

   class dmx_scoreboard;
      rsp_type              expected_q[$];
      int unsigned          mismatches;
      int unsigned          checked;
      logic [BYTE_W-1:0]    levels [0:MAX_CHANNELS_DEF];
      phase_type            phase;
      logic [COUNT_W-1:0]   next_slot;
      logic [COUNT_W-1:0]   slot_total;
      logic                 done;
      logic                 break_pending;
      logic [MS_W-1:0]      ms_count;
      logic [CSR_DAT_W-1:0] start_code;
      logic [CSR_DAT_W-1:0] min_break;

      function new();
         foreach (levels[i]) levels[i] = '0;
         phase         = PH_IDLE;
         next_slot     = '0;
         slot_total    = '0;
         done          = 1'b0;
         break_pending = 1'b0;
         ms_count      = '0;
         start_code    = START_CODE_RST;
         min_break     = MIN_BREAK_RST;
         mismatches    = 0;
         checked       = 0;
      endfunction

      // Mirror a control register write
      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_START_CODE: start_code = data;
            CSR_MIN_BREAK:  min_break  = data;
            default: ;
         endcase
      endfunction

      // Advance the predicted receiver by one accepted word and queue its result
      function void note_request(req_type w);
         rsp_type r;
         r = '0;
         case (w.action)
            ACT_BYTE: begin
               case (phase)
                  PH_IDLE: ;
                  PH_BREAK: begin
                     // the byte after a long enough break is consumed as mark-after-break
                     if (break_pending && ms_count >= min_break) begin
                        phase         = PH_START;
                        next_slot     = '0;
                        break_pending = 1'b0;
                     end else begin
                        phase = PH_IDLE;
                     end
                  end
                  PH_START: begin
                     if (w.rx_byte == start_code) begin
                        levels[0] = w.rx_byte;
                        next_slot = COUNT_W'(1);
                        phase     = PH_DATA;
                     end else begin
                        phase = PH_IDLE;
                     end
                  end
                  PH_DATA: begin
                     if (next_slot <= MAX_CHANNELS_DEF) begin
                        levels[next_slot] = w.rx_byte;
                        next_slot = next_slot + 1'b1;
                        if (next_slot > 2) begin
                           slot_total = next_slot - 1'b1;
                           done       = 1'b1;
                        end
                     end else begin
                        // one byte past the last channel closes the frame
                        slot_total = COUNT_W'(MAX_CHANNELS_DEF);
                        done       = 1'b1;
                        phase      = PH_IDLE;
                     end
                  end
                  default: phase = PH_IDLE;
               endcase
            end
            ACT_ERROR: begin
               if (w.framing_error) begin
                  break_pending = 1'b1;
                  ms_count      = '0;
                  phase         = PH_BREAK;
               end
               if (w.other_error) phase = PH_ERROR;
            end
            ACT_TICK: begin
               if (ms_count != MS_SAT) ms_count = ms_count + 1'b1;
            end
            ACT_READ: begin
               if (w.channel_index != 0 && w.channel_index <= MAX_CHANNELS_DEF)
                  r.channel_value = levels[w.channel_index];
            end
            ACT_RESET_FRAME: begin
               done       = 1'b0;
               next_slot  = '0;
               slot_total = '0;
               phase      = PH_IDLE;
            end
            default: ;
         endcase
         r.frame_done        = done;
         r.channels_received = slot_total;
         r.receiver_state    = phase;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      // Compare one accepted result word with the oldest prediction
      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing pending", got));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.channel_value !== want.channel_value)
            report_mismatch($sformatf("channel_value %h, want %h",
                                      got.channel_value, want.channel_value));
         if (got.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done %b, want %b",
                                      got.frame_done, want.frame_done));
         if (got.channels_received !== want.channels_received)
            report_mismatch($sformatf("channels_received %0d, want %0d",
                                      got.channels_received, want.channels_received));
         if (got.receiver_state !== want.receiver_state)
            report_mismatch($sformatf("receiver_state %0d, want %0d",
                                      got.receiver_state, want.receiver_state));
      endtask
   endclass

endpackage

[bench/tb_dmx512_frame_receiver.sv]
`timescale 1ns / 100ps
// Top-level bench: drives UART event words into the DMX512 frame receiver and checks results.
module tb_dmx512_frame_receiver
   import dmxrx_pkg::*;
   import dmxrx_tb_pkg::*;
();

   localparam int CLK_HIGH     = 4;
   localparam int CLK_LOW      = 4;
   localparam int PHASE_WORDS  = 350;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 12;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   dmx_scoreboard sb;
   int unsigned   cycles      = 0;
   int unsigned   words_sent  = 0;
   int unsigned   long_frames = 0;
   int unsigned   settings    = 1;
   bit            sender_quiet   = 1'b0;
   bit            receiver_quiet = 1'b0;
   int            stall_hold  = 0;
   int            stall_pick;

   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   dmx512_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results pending", cycles, sb.expected_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Watch both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // Stall the result side in runs: mostly open, short holds, a few long ones
   always @(negedge clock) begin
      if (receiver_quiet) begin
         rsp_stall  <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 65) begin
            rsp_stall  <= 1'b0;
            stall_hold = $urandom_range(0, 12);
         end else if (stall_pick < 95) begin
            rsp_stall  <= 1'b1;
            stall_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold = $urandom_range(10, 40);
         end
      end
   end

   function automatic int sender_gap();
      int pick;
      if (sender_quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type make_word(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b,
                                         bit fe, bit oe, logic [INDEX_W-1:0] idx);
      req_type w;
      w.action        = act;
      w.rx_byte       = b;
      w.framing_error = fe;
      w.other_error   = oe;
      w.channel_index = idx;
      return w;
   endfunction

   // Random field values at the width of each field
   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic bit rand_bit();
      return ($urandom_range(0, 1) != 0);
   endfunction

   function automatic logic [INDEX_W-1:0] rand_index();
      return INDEX_W'($urandom);
   endfunction

   // Offer one word after a random gap; enter and leave just after a falling edge
   task automatic send_event(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b,
                             bit fe, bit oe, logic [INDEX_W-1:0] idx);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= make_word(act, b, fe, oe, idx);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // Hold the sender until every predicted result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_register(idx, data);
   endtask

   task automatic apply_setting(logic [CSR_DAT_W-1:0] code, logic [CSR_DAT_W-1:0] brk);
      drain();
      write_register(CSR_START_CODE, code);
      write_register(CSR_MIN_BREAK, brk);
      settings++;
   endtask

   // Mostly valid channels, some boundaries, some anywhere in the index range
   function automatic logic [INDEX_W-1:0] pick_index();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return INDEX_W'($urandom_range(0, 520));
      if (pick < 85) begin
         case ($urandom_range(0, 5))
            0: return '0;
            1: return INDEX_W'(1);
            2: return INDEX_W'(2);
            3: return INDEX_W'(MAX_CHANNELS_DEF - 1);
            4: return INDEX_W'(MAX_CHANNELS_DEF);
            default: return INDEX_W'(MAX_CHANNELS_DEF + 1);
         endcase
      end
      return rand_index();
   endfunction

   task automatic maybe_read();
      if ($urandom_range(0, 7) == 0)
         send_event(ACT_READ, rand_byte(), rand_bit(), rand_bit(), pick_index());
   endtask

   // One frame: break, ticks, mark-after-break, start code, data; some are damaged
   task automatic send_frame(int data_count);
      int fault;
      int ticks;
      logic [BYTE_W-1:0] code;
      fault = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 5) : 0;
      send_event(ACT_ERROR, rand_byte(), 1'b1, fault == 1, rand_index());
      if (fault == 2 && sb.min_break > 0) ticks = $urandom_range(0, sb.min_break - 1);
      else ticks = sb.min_break + $urandom_range(0, 3);
      repeat (ticks) begin
         send_event(ACT_TICK, rand_byte(), rand_bit(), rand_bit(), rand_index());
         maybe_read();
      end
      send_event(ACT_BYTE, rand_byte(), rand_bit(), rand_bit(), rand_index());
      code = sb.start_code;
      if (fault == 3) code = code ^ (8'h01 << $urandom_range(0, 7));
      send_event(ACT_BYTE, code, rand_bit(), rand_bit(), rand_index());
      if (data_count > MAX_CHANNELS_DEF) long_frames++;
      for (int i = 0; i < data_count; i++) begin
         if (fault == 4 && i == data_count / 2)
            send_event(ACT_ERROR, rand_byte(), rand_bit(), 1'b1, rand_index());
         if (fault == 5 && i == data_count / 2)
            send_event(ACT_RESET_FRAME, rand_byte(), rand_bit(), rand_bit(), rand_index());
         send_event(ACT_BYTE, rand_byte(), rand_bit(), rand_bit(), rand_index());
         maybe_read();
      end
   endtask

   // Random traffic: mostly frames with random content, the rest arbitrary words
   task automatic run_traffic(int words);
      int target;
      target = words_sent + words;
      while (words_sent < target) begin
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 39) == 0) send_frame($urandom_range(505, 520));
            else send_frame($urandom_range(0, 24));
         end else begin
            send_event(ACTION_W'($urandom_range(0, ACT_TOP)), rand_byte(), rand_bit(),
                       rand_bit(), rand_index());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset values of the registers (start code 0, one tick of break)
      send_event(ACT_READ, 8'hFF, 1'b1, 1'b1, 10'd0);
      send_event(ACT_BYTE, 8'hFF, 1'b0, 1'b0, 10'h3FF);
      send_event(ACT_ERROR, 8'h00, 1'b1, 1'b1, 10'd0);
      send_event(ACT_BYTE, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_ERROR, 8'hFF, 1'b0, 1'b0, 10'h3FF);
      send_event(ACT_ERROR, 8'h00, 1'b1, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_ERROR, 8'h00, 1'b1, 1'b0, 10'd0);
      send_event(ACT_TICK, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'h55, 1'b0, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'hFF, 1'b0, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'hA5, 1'b0, 1'b0, 10'd0);
      send_event(ACT_READ, 8'h00, 1'b0, 1'b0, 10'd1);
      send_event(ACT_READ, 8'h00, 1'b0, 1'b0, 10'd3);
      send_event(ACT_READ, 8'h00, 1'b0, 1'b0, 10'd512);
      send_event(ACT_READ, 8'h00, 1'b0, 1'b0, 10'd513);
      send_event(ACT_READ, 8'h00, 1'b0, 1'b0, 10'h3FF);
      send_event(ACT_SPARE, 8'hFF, 1'b1, 1'b1, 10'h3FF);
      send_event(ACT_TOP, 8'hFF, 1'b1, 1'b1, 10'h3FF);
      send_event(ACT_RESET_FRAME, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_ERROR, 8'h00, 1'b1, 1'b0, 10'd0);
      send_event(ACT_TICK, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'h00, 1'b0, 1'b0, 10'd0);
      send_event(ACT_BYTE, 8'h01, 1'b0, 1'b0, 10'd0);

      // Random traffic under several register settings
      apply_setting(8'h00, 8'h00);
      run_traffic(PHASE_WORDS);

      // Extremes, with one frame that runs past the last channel
      apply_setting(8'hFF, 8'hFF);
      send_frame(MAX_CHANNELS_DEF + 2);
      run_traffic(PHASE_WORDS);

      // No idling on either side
      apply_setting(rand_byte(), CSR_DAT_W'($urandom_range(1, 6)));
      sender_quiet   = 1'b1;
      receiver_quiet = 1'b1;
      run_traffic(PHASE_WORDS);
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;

      apply_setting(START_CODE_RST, MIN_BREAK_RST);
      run_traffic(PHASE_WORDS);

      // Let the pipeline empty completely halfway through
      apply_setting(rand_byte(), 8'h02);
      run_traffic(PHASE_WORDS / 2);
      drain();
      run_traffic(PHASE_WORDS / 2);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words under %0d register settings, %0d long frames",
               words_sent, settings, long_frames);
      $display("Checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
